// ===== design/tmr_pkg.sv =====
// shared constants, pattern tables and types for the thinning block
`timescale 1ns / 1ps
package tmr_pkg;

  localparam int MAX_W   = 64;
  localparam int MAX_H   = 64;
  localparam int ROW_AW  = $clog2(MAX_H);
  localparam int CNT_W   = $clog2(MAX_H + 2) + 1;
  localparam int CFG_W   = 7;
  localparam int N_KEEP  = 12;

  // register indexes
  localparam int REG_WIDTH  = 0;
  localparam int REG_HEIGHT = 1;

  typedef logic [8:0] pat_t;
  typedef logic [MAX_W-1:0] row_t;

  typedef struct packed {
    row_t row;
    logic any;
  } tmr_res_t;

  // bit k is neighborhood position k, row-major from top-left
  localparam pat_t RM_A_CARE [2] = '{9'b000010010, 9'b000110000};
  localparam pat_t RM_A_VAL  [2] = '{9'b000010000, 9'b000010000};
  localparam pat_t KP_A_CARE [2] = '{9'b110110010, 9'b000111011};
  localparam pat_t KP_A_VAL  [2] = '{9'b010110000, 9'b000011010};
  localparam pat_t RM_B_CARE [2] = '{9'b010010000, 9'b000011000};
  localparam pat_t RM_B_VAL  [2] = '{9'b000010000, 9'b000010000};
  localparam pat_t KP_B_CARE [2] = '{9'b010011011, 9'b110111000};
  localparam pat_t KP_B_VAL  [2] = '{9'b000011010, 9'b010110000};

  localparam pat_t KEEP_CARE [N_KEEP] = '{
    9'b010111000, 9'b010111010, 9'b000111010, 9'b010110010,
    9'b011011000, 9'b000011011, 9'b000110110, 9'b110110000,
    9'b101111111, 9'b111110111, 9'b111111101, 9'b111011111
  };
  localparam pat_t KEEP_VAL [N_KEEP] = '{
    9'b010010000, 9'b000011000, 9'b000010010, 9'b000110000,
    9'b001010000, 9'b000010001, 9'b000010100, 9'b100010000,
    9'b000111010, 9'b010110010, 9'b010111000, 9'b010011010
  };

  function automatic logic pat_hit(input pat_t nb, input pat_t care, input pat_t val);
    pat_hit = (((nb ^ val) & care) == '0);
  endfunction

endpackage

// ===== design/tmr_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module tmr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/tmr_lane.sv =====
// one column lane: pattern match of a 3x3 neighborhood for the active subpass
`timescale 1ns / 1ps
module tmr_lane (
  input  tmr_pkg::pat_t nb,
  input  logic          phase,
  output logic          remove
);
  import tmr_pkg::*;

  logic rm_hit;
  logic kp_hit;

  always_comb begin
    rm_hit = 1'b0;
    kp_hit = 1'b0;
    for (int k = 0; k < 2; k++) begin
      if (phase) begin
        rm_hit = rm_hit | pat_hit(nb, RM_B_CARE[k], RM_B_VAL[k]);
        kp_hit = kp_hit | pat_hit(nb, KP_B_CARE[k], KP_B_VAL[k]);
      end else begin
        rm_hit = rm_hit | pat_hit(nb, RM_A_CARE[k], RM_A_VAL[k]);
        kp_hit = kp_hit | pat_hit(nb, KP_A_CARE[k], KP_A_VAL[k]);
      end
    end
    for (int k = 0; k < N_KEEP; k++) begin
      kp_hit = kp_hit | pat_hit(nb, KEEP_CARE[k], KEEP_VAL[k]);
    end
    remove = nb[4] & rm_hit & ~kp_hit;
  end
endmodule

// ===== design/tmr_subpass.sv =====
// one row of a subpass: a lane per column, then merge into new row and change flag
`timescale 1ns / 1ps
module tmr_subpass (
  input  tmr_pkg::row_t     row_up,
  input  tmr_pkg::row_t     row_mid,
  input  tmr_pkg::row_t     row_dn,
  input  logic              phase,
  output tmr_pkg::tmr_res_t res
);
  import tmr_pkg::*;

  logic [MAX_W+1:0] pad_up, pad_mid, pad_dn;
  row_t             rem;

  // background border on both sides
  assign pad_up  = {1'b0, row_up, 1'b0};
  assign pad_mid = {1'b0, row_mid, 1'b0};
  assign pad_dn  = {1'b0, row_dn, 1'b0};

  for (genvar c = 0; c < MAX_W; c++) begin : g_lane
    pat_t nb;
    assign nb = {pad_dn[c+2], pad_dn[c+1], pad_dn[c],
                 pad_mid[c+2], pad_mid[c+1], pad_mid[c],
                 pad_up[c+2], pad_up[c+1], pad_up[c]};
    tmr_lane u_lane (
      .nb     (nb),
      .phase  (phase),
      .remove (rem[c])
    );
  end

  assign res.row = row_mid & ~rem;
  assign res.any = |rem;
endmodule

// ===== design/binary_image_thinning.sv =====
// top level: row loading, subpass sequencer over two frame rams, row output
// load: one row item per cycle while idle; the frame starts on the last row
// thinning: each subpass streams all rows through the column lanes, and subpasses
// repeat until a subpass removes nothing
// output: rows are read, registered, then held while out_stall is high
// reset: counters and control clear, frame rams hold no defined contents
`timescale 1ns / 1ps
module binary_image_thinning (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [63:0]           in_row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           out_row,
  output logic [5:0]            out_row_number,
  output logic                  out_last_row,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import tmr_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_PASS = 3'd1;
  localparam logic [2:0] S_ERD  = 3'd2;
  localparam logic [2:0] S_ELD  = 3'd3;
  localparam logic [2:0] S_EOUT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] width_r, height_r;
  logic [CNT_W-1:0] loaded_r, loaded_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0] dj_r, dj_nxt;
  logic             dv_r, dv_nxt;
  logic             any_r, any_nxt;
  logic             phase_r, phase_nxt;
  logic             src_r, src_nxt;
  logic [CNT_W-1:0] em_r, em_nxt;
  row_t             up_r, up_nxt, mid_r, mid_nxt;
  row_t             out_row_r, out_row_nxt;
  logic [ROW_AW-1:0] out_num_r, out_num_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0] w_eff, h_eff, load_cnt;
  row_t             wmask, rd0, rd1, rd_src, row_dn;
  tmr_res_t         res;
  logic             we, we0, we1, wsel;
  logic [ROW_AW-1:0] waddr, raddr;
  row_t             wdata;
  logic             in_acc, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == 1'(REG_HEIGHT)) ? {{(32-CFG_W){1'b0}}, height_r}
                                               : {{(32-CFG_W){1'b0}}, width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(MAX_W);
      height_r <= CFG_W'(MAX_H);
    end else if (cfg_wr) begin
      if (paddr[2] == 1'(REG_WIDTH)) begin
        width_r <= pwdata[CFG_W-1:0];
      end else begin
        height_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  // out-of-range sizes clamp to the legal range
  always_comb begin
    w_eff = CNT_W'(width_r);
    if (width_r == '0) w_eff = CNT_W'(1);
    else if (CNT_W'(width_r) > CNT_W'(MAX_W)) w_eff = CNT_W'(MAX_W);
    h_eff = CNT_W'(height_r);
    if (height_r == '0) h_eff = CNT_W'(1);
    else if (CNT_W'(height_r) > CNT_W'(MAX_H)) h_eff = CNT_W'(MAX_H);
    for (int c = 0; c < MAX_W; c++) begin
      wmask[c] = (CNT_W'(c) < w_eff);
    end
  end

  tmr_ram #(.WIDTH(MAX_W), .DEPTH(MAX_H)) u_ram0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
  );
  tmr_ram #(.WIDTH(MAX_W), .DEPTH(MAX_H)) u_ram1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
  );

  assign rd_src = (src_r ? rd1 : rd0) & wmask;
  assign row_dn = (dj_r < h_eff) ? rd_src : '0;

  tmr_subpass u_subpass (
    .row_up  (up_r),
    .row_mid (mid_r),
    .row_dn  (row_dn),
    .phase   (phase_r),
    .res     (res)
  );

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid & ~in_stall;
  assign load_cnt = loaded_r + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    step_nxt      = step_r;
    dj_nxt        = dj_r;
    dv_nxt        = 1'b0;
    any_nxt       = any_r;
    phase_nxt     = phase_r;
    src_nxt       = src_r;
    em_nxt        = em_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    out_row_nxt   = out_row_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    we            = 1'b0;
    wsel          = src_r;
    waddr         = loaded_r[ROW_AW-1:0];
    wdata         = in_row & wmask;
    raddr         = em_r[ROW_AW-1:0];

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          we = 1'b1;
          if (load_cnt >= h_eff) begin
            loaded_nxt = '0;
            state_nxt  = S_PASS;
            step_nxt   = '0;
            any_nxt    = 1'b0;
            phase_nxt  = 1'b0;
            up_nxt     = '0;
            mid_nxt    = '0;
          end else begin
            loaded_nxt = load_cnt;
          end
        end
      end
      S_PASS: begin
        raddr = step_r[ROW_AW-1:0];
        if (step_r <= h_eff) begin
          dv_nxt   = 1'b1;
          dj_nxt   = step_r;
          step_nxt = step_r + CNT_W'(1);
        end
        if (dv_r) begin
          // row dj_r arrives, row dj_r-1 is judged
          up_nxt  = mid_r;
          mid_nxt = row_dn;
          if (dj_r != '0) begin
            we      = 1'b1;
            wsel    = ~src_r;
            waddr   = ROW_AW'(dj_r - CNT_W'(1));
            wdata   = res.row;
            any_nxt = any_r | res.any;
          end
          if (dj_r == h_eff) begin
            src_nxt = ~src_r;
            dv_nxt  = 1'b0;
            if (any_r | res.any) begin
              phase_nxt = ~phase_r;
              step_nxt  = '0;
              any_nxt   = 1'b0;
              up_nxt    = '0;
              mid_nxt   = '0;
            end else begin
              state_nxt = S_ERD;
              em_nxt    = '0;
            end
          end
        end
      end
      S_ERD: begin
        state_nxt = S_ELD;
      end
      S_ELD: begin
        out_row_nxt   = rd_src;
        out_num_nxt   = em_r[ROW_AW-1:0];
        out_last_nxt  = (em_r + CNT_W'(1) == h_eff);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EOUT;
      end
      S_EOUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_LOAD;
            em_nxt    = '0;
          end else begin
            em_nxt    = em_r + CNT_W'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign we0 = we & ~wsel;
  assign we1 = we & wsel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      loaded_r    <= '0;
      step_r      <= '0;
      dj_r        <= '0;
      dv_r        <= 1'b0;
      any_r       <= 1'b0;
      phase_r     <= 1'b0;
      src_r       <= 1'b0;
      em_r        <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      step_r      <= step_nxt;
      dj_r        <= dj_nxt;
      dv_r        <= dv_nxt;
      any_r       <= any_nxt;
      phase_r     <= phase_nxt;
      src_r       <= src_nxt;
      em_r        <= em_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    up_r      <= up_nxt;
    mid_r     <= mid_nxt;
    out_row_r <= out_row_nxt;
    out_num_r <= out_num_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_row_number = out_num_r;
  assign out_last_row   = out_last_r;

  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result row is pending");

  a_one_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(we0 && we1))
    else $error("both frame rams written in one cycle");

  a_last_row_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_row) |-> (CNT_W'(out_row_number) + CNT_W'(1) == h_eff))
    else $error("last row flag on wrong row");

  a_pass_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS) |-> (!out_valid && in_stall))
    else $error("channel active during thinning");

endmodule
